// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sadc_pkg.sv =====
package sadc_pkg;

    localparam int BIT_COUNT_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SHIFT_W    = 16;
    localparam int GAIN_W     = 10;
    localparam int FRAME_W    = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_WORD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADC_OFFSET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 3'd4;

    // reset values
    localparam logic [SHIFT_W-1:0] RST_PULSE_TICKS  = 16'd300;
    localparam logic [SHIFT_W-1:0] RST_COMMAND_WORD = 16'h8000;
    localparam logic [SHIFT_W-1:0] RST_ADC_OFFSET   = 16'd512;
    localparam logic [GAIN_W-1:0]  RST_SAMPLE_GAIN  = 10'd50;
    localparam logic [FRAME_W-1:0] RST_FRAME_LENGTH = 8'd200;

    typedef struct packed {
        logic [SHIFT_W-1:0] pulse_ticks;
        logic [SHIFT_W-1:0] command_word;
        logic [SHIFT_W-1:0] adc_offset;
        logic [GAIN_W-1:0]  sample_gain;
        logic [FRAME_W-1:0] frame_length;
    } t_cfg;

    // one processed tick between sequencer and scaler
    typedef struct packed {
        logic               cs_n;
        logic               sclk;
        logic               mosi;
        logic               smp_valid;
        logic [SHIFT_W-1:0] diff;
        logic               last;
    } t_mid;

endpackage

// ===== rtl/sadc_cfg.sv =====
module sadc_cfg
    import sadc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PULSE_TICKS:  n_cfg.pulse_ticks  = i_cfg_data;
                REG_COMMAND_WORD: n_cfg.command_word = i_cfg_data;
                REG_ADC_OFFSET:   n_cfg.adc_offset   = i_cfg_data;
                REG_SAMPLE_GAIN:  n_cfg.sample_gain  = i_cfg_data[GAIN_W-1:0];
                REG_FRAME_LENGTH: n_cfg.frame_length = i_cfg_data[FRAME_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_ticks  <= RST_PULSE_TICKS;
            r_cfg.command_word <= RST_COMMAND_WORD;
            r_cfg.adc_offset   <= RST_ADC_OFFSET;
            r_cfg.sample_gain  <= RST_SAMPLE_GAIN;
            r_cfg.frame_length <= RST_FRAME_LENGTH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/sadc_seq.sv =====
`include "assert_macros.svh"

module sadc_seq
    import sadc_pkg::*;
#(
    parameter int BIT_COUNT = BIT_COUNT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_tick_valid,
    input  logic i_miso,
    input  logic i_req,
    output logic o_tick_ready,
    output logic o_mid_valid,
    output t_mid o_mid,
    input  logic i_mid_ready
);

    localparam int IDX_W = (BIT_COUNT > 1) ? $clog2(BIT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BIT_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START_LO,
        S_START_HI,
        S_BIT_LO,
        S_BIT_HI
    } t_phase;

    t_phase               r_phase, n_phase;
    logic [SHIFT_W-1:0]   r_delay, n_delay;
    logic [IDX_W-1:0]     r_bit_idx, n_bit_idx;
    logic [SHIFT_W-1:0]   r_cmd, n_cmd;
    logic [SHIFT_W-1:0]   r_data, n_data;
    logic [FRAME_W-1:0]   r_pos, n_pos;
    logic                 r_cs_n, n_cs_n;
    logic                 r_sclk, n_sclk;
    logic                 r_mosi, n_mosi;
    logic                 r_smp_valid, n_smp_valid;
    logic [SHIFT_W-1:0]   r_diff, n_diff;
    logic                 r_last, n_last;
    logic                 r_mid_valid;
    logic [FRAME_W-1:0]   pos_inc;
    logic                 advance;

    assign o_tick_ready = !r_mid_valid || i_mid_ready;
    assign advance      = i_tick_valid && o_tick_ready;
    assign pos_inc      = r_pos + 1'b1;

    always_comb begin
        n_phase     = r_phase;
        n_delay     = r_delay;
        n_bit_idx   = r_bit_idx;
        n_cmd       = r_cmd;
        n_data      = r_data;
        n_pos       = r_pos;
        n_cs_n      = r_cs_n;
        n_sclk      = r_sclk;
        n_mosi      = r_mosi;
        n_smp_valid = 1'b0;
        n_diff      = '0;
        n_last      = 1'b0;
        if (r_phase == S_IDLE) begin
            if (i_req) begin
                n_cs_n    = 1'b0;
                n_sclk    = 1'b0;
                n_mosi    = 1'b1;
                n_cmd     = i_cfg.command_word;
                n_data    = '0;
                n_bit_idx = '0;
                n_delay   = i_cfg.pulse_ticks;
                n_phase   = S_START_LO;
            end
        end else if (r_delay != '0) begin
            n_delay = r_delay - 1'b1;
        end else begin
            unique case (r_phase)
                S_START_LO, S_BIT_LO: begin
                    n_sclk  = 1'b1;
                    n_delay = i_cfg.pulse_ticks;
                    n_phase = (r_phase == S_START_LO) ? S_START_HI : S_BIT_HI;
                end
                S_START_HI: begin
                    n_sclk  = 1'b0;
                    n_mosi  = r_cmd[SHIFT_W-1];
                    n_cmd   = {r_cmd[SHIFT_W-2:0], 1'b0};
                    n_delay = i_cfg.pulse_ticks;
                    n_phase = S_BIT_LO;
                end
                S_BIT_HI: begin
                    n_sclk = 1'b0;
                    n_data = {r_data[SHIFT_W-2:0], i_miso};
                    if (r_bit_idx == LAST_IDX) begin
                        n_cs_n      = 1'b1;
                        n_phase     = S_IDLE;
                        n_bit_idx   = '0;
                        n_smp_valid = 1'b1;
                        n_diff      = n_data - i_cfg.adc_offset;
                        if (pos_inc == i_cfg.frame_length) begin
                            n_last = 1'b1;
                            n_pos  = '0;
                        end else begin
                            n_pos = pos_inc;
                        end
                    end else begin
                        n_bit_idx = r_bit_idx + 1'b1;
                        n_mosi    = r_cmd[SHIFT_W-1];
                        n_cmd     = {r_cmd[SHIFT_W-2:0], 1'b0};
                        n_delay   = i_cfg.pulse_ticks;
                        n_phase   = S_BIT_LO;
                    end
                end
                default: n_phase = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= S_IDLE;
            r_delay     <= '0;
            r_bit_idx   <= '0;
            r_cmd       <= '0;
            r_data      <= '0;
            r_pos       <= '0;
            r_cs_n      <= 1'b1;
            r_sclk      <= 1'b0;
            r_mosi      <= 1'b0;
            r_smp_valid <= 1'b0;
            r_diff      <= '0;
            r_last      <= 1'b0;
            r_mid_valid <= 1'b0;
        end else begin
            if (o_tick_ready) begin
                r_mid_valid <= i_tick_valid;
            end
            if (advance) begin
                r_phase     <= n_phase;
                r_delay     <= n_delay;
                r_bit_idx   <= n_bit_idx;
                r_cmd       <= n_cmd;
                r_data      <= n_data;
                r_pos       <= n_pos;
                r_cs_n      <= n_cs_n;
                r_sclk      <= n_sclk;
                r_mosi      <= n_mosi;
                r_smp_valid <= n_smp_valid;
                r_diff      <= n_diff;
                r_last      <= n_last;
            end
        end
    end

    assign o_mid_valid    = r_mid_valid;
    assign o_mid.cs_n      = r_cs_n;
    assign o_mid.sclk      = r_sclk;
    assign o_mid.mosi      = r_mosi;
    assign o_mid.smp_valid = r_smp_valid;
    assign o_mid.diff      = r_diff;
    assign o_mid.last      = r_last;

    // chip select is released exactly while idle
    `ASSERT_NOW(a_cs_idle, i_clk, i_rst_n, 1'b1, (r_phase == S_IDLE) == r_cs_n,
        "chip select out of step with phase")
    // a sample only comes out on the tick that ends a conversion
    `ASSERT_NOW(a_smp_cs, i_clk, i_rst_n, r_smp_valid, r_cs_n && !r_sclk,
        "sample flagged with bus still active")
    // the sequencer only moves on an accepted tick
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, !advance, $stable(r_phase) && $stable(r_delay),
        "sequencer moved without a tick")

endmodule

// ===== rtl/sadc_scale.sv =====
`include "assert_macros.svh"

module sadc_scale
    import sadc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [GAIN_W-1:0]         i_gain,
    input  logic                      i_mid_valid,
    input  t_mid                      i_mid,
    output logic                      o_mid_ready,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_cs_n,
    output logic                      o_sclk,
    output logic                      o_mosi,
    output logic                      o_smp_valid,
    output logic signed [SHIFT_W-1:0] o_value,
    output logic                      o_last
);

    logic                       r_out_valid;
    logic                       r_cs_n, r_sclk, r_mosi, r_smp_valid, r_last;
    logic [SHIFT_W-1:0]         r_value;
    logic [GAIN_W+SHIFT_W-1:0]  product;

    assign o_mid_ready = !r_out_valid || i_ready;
    assign product     = i_gain * i_mid.diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_mid_ready) begin
            r_out_valid <= i_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mid_valid && o_mid_ready) begin
            r_cs_n      <= i_mid.cs_n;
            r_sclk      <= i_mid.sclk;
            r_mosi      <= i_mid.mosi;
            r_smp_valid <= i_mid.smp_valid;
            r_value     <= i_mid.smp_valid ? product[SHIFT_W-1:0] : '0;
            r_last      <= i_mid.smp_valid && i_mid.last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_cs_n      = r_cs_n;
    assign o_sclk      = r_sclk;
    assign o_mosi      = r_mosi;
    assign o_smp_valid = r_smp_valid;
    assign o_value     = r_value;
    assign o_last      = r_last;

    `ASSERT_NOW(a_last_smp, i_clk, i_rst_n, r_out_valid && r_last, r_smp_valid,
        "frame end marked without a sample")

endmodule

// ===== rtl/spi_adc_sampler.sv =====
// spi_adc_sampler: bit-banged spi master for a serial adc. every input word is one
// tick of the pin sequencer and produces exactly one output word with the pin levels
// after that tick (chip select, sclk, mosi) and, on the tick that ends a conversion,
// the scaled sample gain*(raw-offset) modulo 2^16 plus a last-of-frame flag. a high
// sample request while idle starts a conversion: start bit, then BIT_COUNT data bits
// with the command word out msb first and miso shifted in on each falling sclk edge;
// every pin action but the last (cs release) is followed by pulse_ticks wait ticks; one
// tick is taken per clock unless the output stalls. a word passes three registers
// (input, sequencer, scaling multiplier); the ready path runs back through all three.
// the user must write registers via the plain write port only while idle (unchecked).
module spi_adc_sampler
    import sadc_pkg::*;
#(
    parameter int BIT_COUNT = BIT_COUNT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write port
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    // tick input
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_miso_bit,
    input  logic                      i_sample_request,
    // result output
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_chip_select_n,
    output logic                      o_serial_clock,
    output logic                      o_mosi_bit,
    output logic                      o_sample_valid,
    output logic signed [SHIFT_W-1:0] o_sample_value,
    output logic                      o_frame_last
);

    t_cfg cfg;

    // input register
    logic r_in_valid;
    logic r_in_miso;
    logic r_in_req;
    logic seq_ready;

    // sequencer to scaler
    logic mid_valid;
    t_mid mid;
    logic mid_ready;

    sadc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // input stage takes a new word whenever its slot empties this cycle
    assign o_ready = !r_in_valid || seq_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_miso <= i_miso_bit;
            r_in_req  <= i_sample_request;
        end
    end

    // pin sequencer, one tick per accepted word
    sadc_seq #(
        .BIT_COUNT (BIT_COUNT)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_tick_valid (r_in_valid),
        .i_miso       (r_in_miso),
        .i_req        (r_in_req),
        .o_tick_ready (seq_ready),
        .o_mid_valid  (mid_valid),
        .o_mid        (mid),
        .i_mid_ready  (mid_ready)
    );

    // gain multiply into the output register
    sadc_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gain      (cfg.sample_gain),
        .i_mid_valid (mid_valid),
        .i_mid       (mid),
        .o_mid_ready (mid_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_cs_n      (o_chip_select_n),
        .o_sclk      (o_serial_clock),
        .o_mosi      (o_mosi_bit),
        .o_smp_valid (o_sample_valid),
        .o_value     (o_sample_value),
        .o_last      (o_frame_last)
    );

endmodule
